// File: hw/rtl/lsa_pkg.sv
`timescale 1ns / 1ps

package lsa_pkg;

    // Graph capacity and buffer geometry.
    localparam int MAX_NODES  = 64;
    localparam int SLOT_WORDS = 1024;

    // Widths fixed by the stream fields.
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int POOL_W    = 7;
    localparam int OFFSET_W  = 16;
    localparam int ARENA_W   = 17;
    localparam int SLOTS     = 1 << IDX_W;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 48;

    localparam logic [ARENA_W-1:0] SLOT_WORDS_V = ARENA_W'(SLOT_WORDS);
    localparam logic [CNT_W-1:0]   MAX_NODES_V  = CNT_W'(MAX_NODES);

    // One stored graph node: its producer count and producer indexes.
    typedef struct packed {
        logic [IDX_W-1:0] prod_b;
        logic [IDX_W-1:0] prod_a;
        logic [1:0]       prod_cnt;
    } prod_entry_t;

    localparam int PROD_W = $bits(prod_entry_t);

    // Commands from the sequencer to the slot map.
    typedef struct packed {
        logic             clear;
        logic             alloc;
        logic             free;
        logic [IDX_W-1:0] free_slot;
    } slot_ctrl_t;

    // Slot map status back to the sequencer.
    typedef struct packed {
        logic [IDX_W-1:0]  alloc_slot;
        logic [POOL_W-1:0] pool;
    } slot_stat_t;

endpackage

// File: hw/rtl/liveness_slot_allocator.sv
`timescale 1ns / 1ps

// Liveness-based buffer slot allocator. A dataflow graph is streamed in one
// node per transfer, in topological order; each node names up to two earlier
// producers. Loading accepts one node per cycle. The transfer that carries
// tlast starts the plan, during which s_tready stays low: a last-use pass
// over all N stored nodes, an allocation pass that gives each node the
// lowest free slot and then frees its producers' slots at their last use,
// and finally one result transfer per node. The passes are serial: each
// node-indexed memory has a single read port, which they visit one entry
// at a time. Nodes beyond 64 are dropped and reported in m_tuser of every
// result. The arena size is the peak slot count times 1024 words.
module liveness_slot_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // in_count[1:0], first_input[7:2], second_input[13:8], zero fill [15:14]
    input  logic [lsa_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,   // last_node
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // node_index[5:0], slot[11:6], word_offset[27:12], arena_words[44:28],
    // zero fill [47:45]
    output logic [lsa_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser,   // overflow
    output logic                           m_tlast    // last_result
);

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_LC_FETCH = 4'd1;
    localparam logic [3:0] ST_LC_A     = 4'd2;
    localparam logic [3:0] ST_LC_B     = 4'd3;
    localparam logic [3:0] ST_PL_ALLOC = 4'd4;
    localparam logic [3:0] ST_PL_FREEA = 4'd5;
    localparam logic [3:0] ST_PL_FREEB = 4'd6;
    localparam logic [3:0] ST_OUT_LD   = 4'd7;
    localparam logic [3:0] ST_OUT_HOLD = 4'd8;

    logic [3:0]                  state_reg;
    logic [3:0]                  state_next;
    logic [lsa_pkg::CNT_W-1:0]   node_cnt_reg;
    logic [lsa_pkg::CNT_W-1:0]   node_cnt_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic [lsa_pkg::CNT_W-1:0]   idx_reg;
    logic [lsa_pkg::CNT_W-1:0]   idx_next;
    logic [lsa_pkg::IDX_W-1:0]   opa_reg;
    logic [lsa_pkg::IDX_W-1:0]   opa_next;
    logic [lsa_pkg::IDX_W-1:0]   opb_reg;
    logic [lsa_pkg::IDX_W-1:0]   opb_next;
    logic                        va_reg;
    logic                        va_next;
    logic                        vb_reg;
    logic                        vb_next;
    logic [lsa_pkg::SLOTS-1:0]   lc_valid_reg;
    logic [lsa_pkg::SLOTS-1:0]   lc_valid_next;
    logic                        lc_vld_reg;

    logic                        m_tvalid_reg;
    logic                        m_tvalid_next;
    logic [lsa_pkg::IDX_W-1:0]   out_node_reg;
    logic [lsa_pkg::IDX_W-1:0]   out_slot_reg;
    logic [lsa_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [lsa_pkg::ARENA_W-1:0] out_arena_reg;
    logic                        out_ovf_reg;
    logic                        out_last_reg;
    logic                        out_load;

    // Memory ports.
    logic                        prod_we;
    logic [lsa_pkg::IDX_W-1:0]   prod_waddr;
    lsa_pkg::prod_entry_t        prod_wdata;
    logic                        prod_re;
    logic [lsa_pkg::IDX_W-1:0]   prod_raddr;
    lsa_pkg::prod_entry_t        prod_q;
    logic                        lc_we;
    logic [lsa_pkg::IDX_W-1:0]   lc_waddr;
    logic [lsa_pkg::IDX_W-1:0]   lc_q;
    logic                        as_we;
    logic [lsa_pkg::IDX_W-1:0]   as_q;
    logic                        rd_re;
    logic [lsa_pkg::IDX_W-1:0]   rd_raddr;

    lsa_pkg::slot_ctrl_t         slot_ctrl;
    lsa_pkg::slot_stat_t         slot_stat;

    logic                        in_xfer;
    logic                        out_xfer;
    logic [1:0]                  in_cnt_clamped;
    logic                        va_c;
    logic                        vb_c;
    logic                        idx_is_final;
    logic [lsa_pkg::CNT_W-1:0]   idx_inc;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_LOAD);

    // A producer count of three behaves as two.
    assign in_cnt_clamped = (s_tdata[1:0] == 2'd3) ? 2'd2 : s_tdata[1:0];

    // An operand counts only when it is present and names an earlier node.
    assign va_c = (prod_q.prod_cnt != 2'd0)
                  && ({1'b0, prod_q.prod_a} < idx_reg);
    assign vb_c = prod_q.prod_cnt[1]
                  && ({1'b0, prod_q.prod_b} < idx_reg);

    assign idx_inc      = idx_reg + lsa_pkg::CNT_W'(1);
    assign idx_is_final = (idx_inc == node_cnt_reg);

    assign prod_we    = in_xfer && (node_cnt_reg < lsa_pkg::MAX_NODES_V);
    assign prod_waddr = node_cnt_reg[lsa_pkg::IDX_W-1:0];
    assign prod_wdata = '{prod_b:   s_tdata[13:8],
                          prod_a:   s_tdata[7:2],
                          prod_cnt: in_cnt_clamped};

    always_comb
    begin
        state_next    = state_reg;
        node_cnt_next = node_cnt_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        lc_valid_next = lc_valid_reg;
        m_tvalid_next = m_tvalid_reg;
        out_load      = 1'b0;
        prod_re       = 1'b0;
        prod_raddr    = idx_reg[lsa_pkg::IDX_W-1:0];
        lc_we         = 1'b0;
        lc_waddr      = opa_reg;
        as_we         = 1'b0;
        rd_re         = 1'b0;
        rd_raddr      = opa_reg;
        slot_ctrl     = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (prod_we)
                    begin
                        node_cnt_next = node_cnt_reg + lsa_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        idx_next      = '0;
                        lc_valid_next = '0;
                        slot_ctrl.clear = 1'b1;
                        state_next    = ST_LC_FETCH;
                    end
                end
            end
            ST_LC_FETCH:
            begin
                prod_re    = 1'b1;
                state_next = ST_LC_A;
            end
            ST_LC_A:
            begin
                // Nodes are visited in rising order, so the latest write to
                // an entry is always the largest consumer index.
                lc_we    = va_c;
                lc_waddr = prod_q.prod_a;
                if (va_c)
                begin
                    lc_valid_next[prod_q.prod_a] = 1'b1;
                end
                opb_next   = prod_q.prod_b;
                vb_next    = vb_c;
                state_next = ST_LC_B;
            end
            ST_LC_B:
            begin
                lc_we    = vb_reg;
                lc_waddr = opb_reg;
                if (vb_reg)
                begin
                    lc_valid_next[opb_reg] = 1'b1;
                end
                prod_re = 1'b1;
                if (idx_is_final)
                begin
                    idx_next   = '0;
                    prod_raddr = '0;
                    state_next = ST_PL_ALLOC;
                end
                else
                begin
                    idx_next   = idx_inc;
                    prod_raddr = idx_inc[lsa_pkg::IDX_W-1:0];
                    state_next = ST_LC_A;
                end
            end
            ST_PL_ALLOC:
            begin
                slot_ctrl.alloc = 1'b1;
                as_we    = 1'b1;
                opa_next = prod_q.prod_a;
                opb_next = prod_q.prod_b;
                va_next  = va_c;
                vb_next  = vb_c;
                // Valid producers are earlier nodes, so for them this read never
                // meets the entry being written for the current node.
                rd_re    = 1'b1;
                rd_raddr = prod_q.prod_a;
                state_next = ST_PL_FREEA;
            end
            ST_PL_FREEA:
            begin
                slot_ctrl.free = va_reg && lc_vld_reg
                                 && (lc_q == idx_reg[lsa_pkg::IDX_W-1:0]);
                slot_ctrl.free_slot = as_q;
                rd_re    = 1'b1;
                rd_raddr = opb_reg;
                state_next = ST_PL_FREEB;
            end
            ST_PL_FREEB:
            begin
                slot_ctrl.free = vb_reg && lc_vld_reg
                                 && (lc_q == idx_reg[lsa_pkg::IDX_W-1:0]);
                slot_ctrl.free_slot = as_q;
                if (idx_is_final)
                begin
                    idx_next   = '0;
                    rd_re      = 1'b1;
                    rd_raddr   = '0;
                    state_next = ST_OUT_LD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    prod_re    = 1'b1;
                    prod_raddr = idx_inc[lsa_pkg::IDX_W-1:0];
                    state_next = ST_PL_ALLOC;
                end
            end
            ST_OUT_LD:
            begin
                out_load      = 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = ST_OUT_HOLD;
            end
            ST_OUT_HOLD:
            begin
                if (out_xfer)
                begin
                    m_tvalid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        idx_next      = '0;
                        node_cnt_next = '0;
                        ovf_next      = 1'b0;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        rd_re      = 1'b1;
                        rd_raddr   = idx_inc[lsa_pkg::IDX_W-1:0];
                        state_next = ST_OUT_LD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            node_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            lc_valid_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            node_cnt_reg <= node_cnt_next;
            ovf_reg      <= ovf_next;
            idx_reg      <= idx_next;
            va_reg       <= va_next;
            vb_reg       <= vb_next;
            lc_valid_reg <= lc_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        if (rd_re)
        begin
            lc_vld_reg <= lc_valid_reg[rd_raddr];
        end
        if (out_load)
        begin
            out_node_reg   <= idx_reg[lsa_pkg::IDX_W-1:0];
            out_slot_reg   <= as_q;
            out_offset_reg <= lsa_pkg::OFFSET_W'(lsa_pkg::ARENA_W'(as_q)
                                                 * lsa_pkg::SLOT_WORDS_V);
            out_arena_reg  <= lsa_pkg::ARENA_W'(slot_stat.pool)
                              * lsa_pkg::SLOT_WORDS_V;
            out_ovf_reg    <= ovf_reg;
            out_last_reg   <= idx_is_final;
        end
    end

    lsa_ram #(
        .DATA_W (lsa_pkg::PROD_W),
        .ADDR_W (lsa_pkg::IDX_W)
    ) u_prod_ram (
        .clk   (clk),
        .we    (prod_we),
        .waddr (prod_waddr),
        .wdata (prod_wdata),
        .re    (prod_re),
        .raddr (prod_raddr),
        .rdata (prod_q)
    );

    // Last consumer of each node; entries not written this plan are masked
    // by the valid bits.
    lsa_ram #(
        .DATA_W (lsa_pkg::IDX_W),
        .ADDR_W (lsa_pkg::IDX_W)
    ) u_lc_ram (
        .clk   (clk),
        .we    (lc_we),
        .waddr (lc_waddr),
        .wdata (idx_reg[lsa_pkg::IDX_W-1:0]),
        .re    (rd_re),
        .raddr (rd_raddr),
        .rdata (lc_q)
    );

    // Slot assigned to each node's output.
    lsa_ram #(
        .DATA_W (lsa_pkg::IDX_W),
        .ADDR_W (lsa_pkg::IDX_W)
    ) u_as_ram (
        .clk   (clk),
        .we    (as_we),
        .waddr (idx_reg[lsa_pkg::IDX_W-1:0]),
        .wdata (slot_stat.alloc_slot),
        .re    (rd_re),
        .raddr (rd_raddr),
        .rdata (as_q)
    );

    lsa_slot_map u_slot_map (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (slot_ctrl),
        .stat  (slot_stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_arena_reg, out_offset_reg, out_slot_reg, out_node_reg};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // Loading and result delivery never overlap.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    // After the final result the block is ready for the next graph.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after the final result");

    // Every reported slot lies inside the planned pool.
    assert property (@(posedge clk) disable iff (!rst_n)
                     m_tvalid |-> ({1'b0, out_slot_reg} < slot_stat.pool))
        else $error("slot outside the pool");

    // The stored node count never exceeds capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
                     node_cnt_reg <= lsa_pkg::MAX_NODES_V)
        else $error("node count above capacity");
`endif

endmodule

// File: hw/rtl/lsa_ram.sv
`timescale 1ns / 1ps

module lsa_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/lsa_slot_map.sv
`timescale 1ns / 1ps

module lsa_slot_map (
    input  logic                clk,
    input  logic                rst_n,
    input  lsa_pkg::slot_ctrl_t ctrl,
    output lsa_pkg::slot_stat_t stat
);

    logic [lsa_pkg::SLOTS-1:0]  busy_reg;
    logic [lsa_pkg::SLOTS-1:0]  busy_next;
    logic [lsa_pkg::POOL_W-1:0] pool_reg;
    logic [lsa_pkg::POOL_W-1:0] pool_next;
    logic [lsa_pkg::SLOTS-1:0]  pool_mask;
    logic [lsa_pkg::SLOTS-1:0]  avail;
    logic [lsa_pkg::SLOTS-1:0]  lowest;
    logic [lsa_pkg::IDX_W-1:0]  first_idx;
    logic                       any_free;
    logic [lsa_pkg::IDX_W-1:0]  alloc_slot;

    // Only slots below the pool size are candidates; the lowest free one is
    // isolated with the two's complement trick and then encoded.
    always_comb
    begin
        if (pool_reg[lsa_pkg::POOL_W-1])
        begin
            pool_mask = '1;
        end
        else
        begin
            pool_mask = (lsa_pkg::SLOTS'(1) << pool_reg[lsa_pkg::IDX_W-1:0])
                        - lsa_pkg::SLOTS'(1);
        end
        avail    = ~busy_reg & pool_mask;
        lowest   = avail & (~avail + lsa_pkg::SLOTS'(1));
        any_free = |avail;
        first_idx = '0;
        for (int b = 0; b < lsa_pkg::SLOTS; b++)
        begin
            first_idx = first_idx | (lowest[b] ? lsa_pkg::IDX_W'(b) : '0);
        end
        alloc_slot = any_free ? first_idx : pool_reg[lsa_pkg::IDX_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        pool_next = pool_reg;
        if (ctrl.clear)
        begin
            busy_next = '0;
            pool_next = '0;
        end
        else
        begin
            if (ctrl.alloc)
            begin
                busy_next[alloc_slot] = 1'b1;
                if (!any_free && !pool_reg[lsa_pkg::POOL_W-1])
                begin
                    pool_next = pool_reg + lsa_pkg::POOL_W'(1);
                end
            end
            if (ctrl.free)
            begin
                busy_next[ctrl.free_slot] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            pool_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pool_reg <= pool_next;
        end
    end

    assign stat.alloc_slot = alloc_slot;
    assign stat.pool       = pool_reg;

endmodule
